[rtl/assert_macros.svh]
// assertion helper macros for the frequency table checker
// no dependencies; taken in by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that must hold at every clock edge outside reset
`define TBFT_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("tbft assertion failed");

// consequence that must hold in the cycle after the antecedent
`define TBFT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("tbft assertion failed");

`endif

[rtl/tbft_pkg.sv]
// shared types, codes and constants of the tail bucket frequency table
// no dependencies; used by every rtl file of the block but assert_macros.svh
`default_nettype none

package tbft_pkg;

  localparam int unsigned BUCKETS_DEF = 1024;

  localparam int unsigned CODE_W     = 64;
  localparam int unsigned LEN_W      = 7;
  localparam int unsigned RAND_W     = 32;
  localparam int unsigned FREQ_W     = 16;
  localparam int unsigned OUTCOME_W  = 3;
  localparam int unsigned SLOT_OUT_W = 10;
  localparam int unsigned CNT_W      = 11;
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned STEP_W     = 7;

  localparam logic [FREQ_W-1:0] FREQ_MAX = 16'hFFFF;

  // function codes
  localparam logic [1:0] FUNC_INSERT = 2'd0;
  localparam logic [1:0] FUNC_QUERY  = 2'd1;
  localparam logic [1:0] FUNC_CLEAR  = 2'd2;
  // unused code, taken and dropped without a result
  localparam logic [1:0] FUNC_NONE   = 2'd3;

  // collision policies held in the replace_mode register
  localparam logic MODE_DECAY = 1'b0;
  localparam logic MODE_PROB  = 1'b1;

  // result outcome codes
  localparam logic [OUTCOME_W-1:0] OUT_NEW      = 3'd0;
  localparam logic [OUTCOME_W-1:0] OUT_MATCH    = 3'd1;
  localparam logic [OUTCOME_W-1:0] OUT_KEPT     = 3'd2;
  localparam logic [OUTCOME_W-1:0] OUT_REPLACED = 3'd3;
  localparam logic [OUTCOME_W-1:0] OUT_MISS     = 3'd4;
  localparam logic [OUTCOME_W-1:0] OUT_CLEARED  = 3'd5;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_BUCKET_COUNT = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_REPLACE_MODE = 1'd1;

  localparam logic [CNT_W-1:0] BUCKET_COUNT_RST = 11'd1024;

  // divider pass lengths
  localparam logic [STEP_W-1:0] STEPS_SLOT = 7'd64;
  localparam logic [STEP_W-1:0] STEPS_RAND = 7'd32;

  typedef struct packed {
    logic [1:0]        func;
    logic [CODE_W-1:0] key_code;
    logic [LEN_W-1:0]  key_length;
    logic [RAND_W-1:0] random_word;
  } in_t;

  typedef struct packed {
    logic [FREQ_W-1:0]     frequency;
    logic [OUTCOME_W-1:0]  outcome;
    logic [SLOT_OUT_W-1:0] slot_index;
  } out_t;

  typedef struct packed {
    logic              valid;
    logic [LEN_W-1:0]  length;
    logic [FREQ_W-1:0] freq;
    logic [CODE_W-1:0] code;
  } entry_t;

  typedef struct packed {
    logic              start;
    logic [STEP_W-1:0] steps;
    logic [CODE_W-1:0] dividend;
    logic [FREQ_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic [FREQ_W-1:0] rem;
  } div_rsp_t;

  typedef enum logic [2:0] {
    ST_SWEEP,
    ST_IDLE,
    ST_SLOT,
    ST_READ,
    ST_EVAL,
    ST_RAND,
    ST_EMIT
  } state_e;

endpackage

`default_nettype wire

[rtl/tbft_div.sv]
// shared restoring divider, one quotient bit per cycle, remainder only
// depends on tbft_pkg
`default_nettype none

module tbft_div (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire tbft_pkg::div_req_t req_i,
  output tbft_pkg::div_rsp_t      rsp_o
);

  logic                                busy_q, busy_d;
  logic                                done_q, done_d;
  logic [tbft_pkg::STEP_W-1:0]         cnt_q, cnt_d;
  logic [tbft_pkg::CODE_W-1:0]         dvd_q, dvd_d;
  logic [tbft_pkg::FREQ_W-1:0]         dsr_q, dsr_d;
  logic [tbft_pkg::FREQ_W-1:0]         rem_q, rem_d;
  logic [tbft_pkg::FREQ_W:0]           shifted;
  logic [tbft_pkg::FREQ_W:0]           diff;

  assign shifted = {rem_q, dvd_q[tbft_pkg::CODE_W-1]};
  assign diff    = shifted - {1'b0, dsr_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    dvd_d  = dvd_q;
    dsr_d  = dsr_q;
    rem_d  = rem_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = req_i.steps;
      dvd_d  = req_i.dividend;
      dsr_d  = req_i.divisor;
      rem_d  = '0;
    end else if (busy_q) begin
      dvd_d = dvd_q << 1;
      // keep the difference when the divisor fits
      if (shifted >= {1'b0, dsr_q}) begin
        rem_d = diff[tbft_pkg::FREQ_W-1:0];
      end else begin
        rem_d = shifted[tbft_pkg::FREQ_W-1:0];
      end
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == tbft_pkg::STEP_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_q <= dvd_d;
    dsr_q <= dsr_d;
    rem_q <= rem_d;
  end

  assign rsp_o.done = done_q;
  assign rsp_o.rem  = rem_q;

endmodule

`default_nettype wire

[rtl/tbft_mem.sv]
// bucket memory, one write port and one registered read port
// depends on tbft_pkg for the entry layout
`default_nettype none

module tbft_mem #(
  parameter int unsigned DEPTH = tbft_pkg::BUCKETS_DEF,
  parameter int unsigned AW    = 10
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire tbft_pkg::entry_t wdata_i,
  input  wire logic [AW-1:0]    raddr_i,
  output tbft_pkg::entry_t      rdata_o
);

  tbft_pkg::entry_t mem_q [DEPTH];
  tbft_pkg::entry_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

[rtl/tail_bucket_frequency_table_core.sv]
// direct-mapped bucket frequency table with decay or probabilistic replacement
// depends on tbft_pkg, tbft_div and tbft_mem
//
// usage
//   input channel in_valid_i / in_stall_o carries one item: func, key_code,
//   key_length, random_word; the block takes one item at a time
//   output channel out_valid_o / out_stall_i carries one result item per
//   insert, query or clear; func 3 is swallowed and gives no result
//   config writes go over cfg_valid_i / cfg_ready_o with cfg_index_i and
//   cfg_data_i, and are to be made only while the block is idle
// steps
//   insert or query: slot division, memory read, evaluation, then emit
//   probabilistic collision: a further division pass for random mod frequency,
//   both passes going through the one shared divider
//   clear: a sweep over all BUCKETS rows, one memory row invalidated per cycle
// reset
//   after reset a clearing pass over all BUCKETS rows runs and in_stall_o stays high
// stalls
//   a finished result waits in the output register while out_stall_i is
//   high; the next item is taken meanwhile and parks in its emit state
`default_nettype none

module tail_bucket_frequency_table_core #(
  parameter int unsigned BUCKETS = tbft_pkg::BUCKETS_DEF
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             in_valid_i,
  output logic                                  in_stall_o,
  input  wire tbft_pkg::in_t                    in_i,
  output logic                                  out_valid_o,
  input  wire logic                             out_stall_i,
  output tbft_pkg::out_t                        out_o,
  input  wire logic                             cfg_valid_i,
  output logic                                  cfg_ready_o,
  input  wire logic [tbft_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  wire logic [tbft_pkg::CNT_W-1:0]       cfg_data_i
);

  // slot address width
  localparam int unsigned SW = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
  localparam logic [16:0] BUCKETS_W  = 17'(BUCKETS);
  localparam logic [SW-1:0] LAST_ROW = SW'(BUCKETS - 1);

  tbft_pkg::state_e state_q, state_d;

  logic [SW-1:0]                 sweep_q, sweep_d;
  logic                          clr_pend_q, clr_pend_d;
  tbft_pkg::in_t                 item_q, item_d;
  logic [SW-1:0]                 slot_q, slot_d;
  logic [tbft_pkg::FREQ_W-1:0]   freq_q, freq_d;
  tbft_pkg::entry_t              ent_q, ent_d;
  tbft_pkg::out_t                res_q, res_d;
  tbft_pkg::out_t                out_q, out_d;
  logic                          out_valid_q, out_valid_d;

  logic [tbft_pkg::CNT_W-1:0]    bucket_count_q;
  logic                          replace_mode_q;
  logic [tbft_pkg::CNT_W-1:0]    active_cnt;

  tbft_pkg::div_req_t            div_req;
  tbft_pkg::div_rsp_t            div_rsp;

  logic                          mem_we;
  logic [SW-1:0]                 mem_waddr;
  tbft_pkg::entry_t              mem_wdata;
  tbft_pkg::entry_t              rd_ent;

  logic                          hit;
  logic [tbft_pkg::FREQ_W-1:0]   f_inc;
  logic [tbft_pkg::FREQ_W-1:0]   f_dec;
  tbft_pkg::entry_t              take_ent;
  logic [tbft_pkg::SLOT_OUT_W-1:0] slot_out;

  // ---------------------------------------------------------------------
  // configuration registers
  // ---------------------------------------------------------------------
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bucket_count_q <= tbft_pkg::BUCKET_COUNT_RST;
      replace_mode_q <= tbft_pkg::MODE_DECAY;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        tbft_pkg::CFG_BUCKET_COUNT: bucket_count_q <= cfg_data_i;
        tbft_pkg::CFG_REPLACE_MODE: replace_mode_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // zero acts as one, anything above the table size as the table size
  always_comb begin
    if (bucket_count_q == '0) begin
      active_cnt = tbft_pkg::CNT_W'(1);
    end else if ({6'b0, bucket_count_q} > BUCKETS_W) begin
      active_cnt = tbft_pkg::CNT_W'(BUCKETS);
    end else begin
      active_cnt = bucket_count_q;
    end
  end

  // ---------------------------------------------------------------------
  // shared divider and bucket memory
  // ---------------------------------------------------------------------
  tbft_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  tbft_mem #(
    .DEPTH (BUCKETS),
    .AW    (SW)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (slot_q),
    .rdata_o (rd_ent)
  );

  // ---------------------------------------------------------------------
  // bucket evaluation on the read-back entry
  // ---------------------------------------------------------------------
  assign hit   = rd_ent.valid && (rd_ent.code == item_q.key_code) &&
                 (rd_ent.length == item_q.key_length);
  assign f_inc = (rd_ent.freq == tbft_pkg::FREQ_MAX) ? rd_ent.freq : rd_ent.freq + 1'b1;
  assign f_dec = rd_ent.freq - 1'b1;

  assign take_ent.valid  = 1'b1;
  assign take_ent.length = item_q.key_length;
  assign take_ent.freq   = tbft_pkg::FREQ_W'(1);
  assign take_ent.code   = item_q.key_code;

  assign slot_out = tbft_pkg::SLOT_OUT_W'(slot_q);

  // ---------------------------------------------------------------------
  // sequencer
  // ---------------------------------------------------------------------
  always_comb begin
    state_d     = state_q;
    sweep_d     = sweep_q;
    clr_pend_d  = clr_pend_q;
    item_d      = item_q;
    slot_d      = slot_q;
    freq_d      = freq_q;
    ent_d       = ent_q;
    res_d       = res_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && out_stall_i;

    div_req          = '0;
    div_req.steps    = tbft_pkg::STEPS_SLOT;
    div_req.dividend = in_i.key_code;
    div_req.divisor  = {5'b0, active_cnt};

    mem_we    = 1'b0;
    mem_waddr = slot_q;
    mem_wdata = take_ent;

    case (state_q)
      tbft_pkg::ST_SWEEP: begin
        // invalidate one row per cycle
        mem_we    = 1'b1;
        mem_waddr = sweep_q;
        mem_wdata = '0;
        sweep_d   = sweep_q + 1'b1;
        if (sweep_q == LAST_ROW) begin
          sweep_d = '0;
          if (clr_pend_q) begin
            clr_pend_d       = 1'b0;
            res_d.frequency  = '0;
            res_d.outcome    = tbft_pkg::OUT_CLEARED;
            res_d.slot_index = '0;
            state_d          = tbft_pkg::ST_EMIT;
          end else begin
            state_d = tbft_pkg::ST_IDLE;
          end
        end
      end

      tbft_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          item_d = in_i;
          case (in_i.func)
            tbft_pkg::FUNC_CLEAR: begin
              clr_pend_d = 1'b1;
              sweep_d    = '0;
              state_d    = tbft_pkg::ST_SWEEP;
            end
            tbft_pkg::FUNC_INSERT, tbft_pkg::FUNC_QUERY: begin
              // slot = key_code mod active bucket count
              div_req.start = 1'b1;
              state_d       = tbft_pkg::ST_SLOT;
            end
            default: ;
          endcase
        end
      end

      tbft_pkg::ST_SLOT: begin
        if (div_rsp.done) begin
          slot_d  = div_rsp.rem[SW-1:0];
          state_d = tbft_pkg::ST_READ;
        end
      end

      tbft_pkg::ST_READ: begin
        state_d = tbft_pkg::ST_EVAL;
      end

      tbft_pkg::ST_EVAL: begin
        res_d.slot_index = slot_out;
        state_d          = tbft_pkg::ST_EMIT;
        if (item_q.func == tbft_pkg::FUNC_QUERY) begin
          if (hit) begin
            res_d.frequency = rd_ent.freq;
            res_d.outcome   = tbft_pkg::OUT_MATCH;
          end else begin
            res_d.frequency = tbft_pkg::FREQ_W'(1);
            res_d.outcome   = tbft_pkg::OUT_MISS;
          end
        end else if (!rd_ent.valid) begin
          mem_we          = 1'b1;
          res_d.frequency = tbft_pkg::FREQ_W'(1);
          res_d.outcome   = tbft_pkg::OUT_NEW;
        end else if (hit) begin
          mem_we          = 1'b1;
          mem_wdata       = rd_ent;
          mem_wdata.freq  = f_inc;
          res_d.frequency = f_inc;
          res_d.outcome   = tbft_pkg::OUT_MATCH;
        end else if (replace_mode_q == tbft_pkg::MODE_DECAY) begin
          // decay: count down, hand over the bucket at zero
          mem_we = 1'b1;
          if (f_dec == '0) begin
            res_d.frequency = tbft_pkg::FREQ_W'(1);
            res_d.outcome   = tbft_pkg::OUT_REPLACED;
          end else begin
            mem_wdata       = rd_ent;
            mem_wdata.freq  = f_dec;
            res_d.frequency = f_dec;
            res_d.outcome   = tbft_pkg::OUT_KEPT;
          end
        end else begin
          // probabilistic: count up, then test random mod frequency
          freq_d           = f_inc;
          ent_d            = rd_ent;
          div_req.start    = 1'b1;
          div_req.steps    = tbft_pkg::STEPS_RAND;
          div_req.dividend = {item_q.random_word, 32'd0};
          div_req.divisor  = f_inc;
          state_d          = tbft_pkg::ST_RAND;
        end
      end

      tbft_pkg::ST_RAND: begin
        if (div_rsp.done) begin
          mem_we = 1'b1;
          if (div_rsp.rem == '0) begin
            res_d.frequency = tbft_pkg::FREQ_W'(1);
            res_d.outcome   = tbft_pkg::OUT_REPLACED;
          end else begin
            mem_wdata       = ent_q;
            mem_wdata.freq  = freq_q;
            res_d.frequency = freq_q;
            res_d.outcome   = tbft_pkg::OUT_KEPT;
          end
          state_d = tbft_pkg::ST_EMIT;
        end
      end

      tbft_pkg::ST_EMIT: begin
        // hand over once the output register is free or being drained
        if (!out_valid_q || !out_stall_i) begin
          out_d       = res_q;
          out_valid_d = 1'b1;
          state_d     = tbft_pkg::ST_IDLE;
        end
      end

      default: begin
        state_d = tbft_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= tbft_pkg::ST_SWEEP;
      sweep_q     <= '0;
      clr_pend_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      sweep_q     <= sweep_d;
      clr_pend_q  <= clr_pend_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q <= item_d;
    slot_q <= slot_d;
    freq_q <= freq_d;
    ent_q  <= ent_d;
    res_q  <= res_d;
    out_q  <= out_d;
  end

  assign in_stall_o  = (state_q != tbft_pkg::ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

endmodule

`default_nettype wire

[rtl/tbft_checker.sv]
// port-level checks of the frequency table core, attached by bind
// depends on tbft_pkg, assert_macros.svh and the top level
`default_nettype none
`include "assert_macros.svh"

module tbft_checker (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           in_valid_i,
  input  wire logic                           in_stall_i,
  input  wire tbft_pkg::in_t                  in_i,
  input  wire logic                           out_valid_i,
  input  wire logic                           out_stall_i,
  input  wire tbft_pkg::out_t                 out_i
);

  // a held result stays offered and unchanged
  `TBFT_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_i && out_stall_i, out_valid_i)
  `TBFT_ASSERT_NEXT(a_out_stable, clk_i, rst_ni, out_valid_i && out_stall_i, $stable(out_i))

  // a real operation keeps the block busy in the following cycle
  `TBFT_ASSERT_NEXT(a_busy_after_take, clk_i, rst_ni,
    in_valid_i && !in_stall_i && (in_i.func != tbft_pkg::FUNC_NONE), in_stall_i)

  // cleared results carry zeros, all others a non-zero frequency
  `TBFT_ASSERT(a_result_shape, clk_i, rst_ni,
    !out_valid_i ||
    ((out_i.outcome == tbft_pkg::OUT_CLEARED) ?
      (out_i.frequency == '0 && out_i.slot_index == '0) : (out_i.frequency != '0)))

endmodule

bind tail_bucket_frequency_table_core tbft_checker u_tbft_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_i  (in_stall_o),
  .in_i        (in_i),
  .out_valid_i (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_i       (out_o)
);

`default_nettype wire

[sim/tb.sv]
// self-checking testbench for the tail bucket frequency table core
// depends on tbft_pkg and tail_bucket_frequency_table_core; a local table
// model predicts every result item, with random idling on both channels
`default_nettype none

module tb;

  // quiet cycles after a drain, long enough for a swallowed item to finish
  localparam int unsigned SETTLE_CYCLES = 200;
  localparam int unsigned PHASES        = 10;
  localparam int unsigned PHASE_ITEMS   = 130;
  localparam int unsigned POOL_KEYS     = 9;

  // bucket counts per random phase; entries 5 and 8 are drawn at random, the zero at 6 is used as is
  localparam int unsigned PHASE_COUNTS [PHASES] = '{1, 2047, 7, 1024, 2, 0, 0, 64, 0, 3};

  logic clk;
  logic rst_n = 1'b0;

  logic                           in_valid  = 1'b0;
  tbft_pkg::in_t                  in_item   = '0;
  logic                           in_stall;
  logic                           out_valid;
  logic                           out_stall = 1'b0;
  tbft_pkg::out_t                 out_item;
  logic                           cfg_valid = 1'b0;
  logic                           cfg_ready;
  logic [tbft_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [tbft_pkg::CNT_W-1:0]     cfg_data  = '0;

  // stimulus waiting for the driver, and results the table should give next
  tbft_pkg::in_t  pending_items   [$];
  tbft_pkg::out_t awaited_results [$];

  // local copy of the table and of its registers
  logic [tbft_pkg::CODE_W-1:0] tbl_code  [tbft_pkg::BUCKETS_DEF];
  logic [tbft_pkg::LEN_W-1:0]  tbl_len   [tbft_pkg::BUCKETS_DEF];
  logic [tbft_pkg::FREQ_W-1:0] tbl_freq  [tbft_pkg::BUCKETS_DEF];
  bit                          tbl_valid [tbft_pkg::BUCKETS_DEF];
  logic [tbft_pkg::CNT_W-1:0]  cfg_count = tbft_pkg::BUCKET_COUNT_RST;
  logic                        cfg_prob  = tbft_pkg::MODE_DECAY;

  // keys of the current phase, grouped three to a slot so they collide
  logic [tbft_pkg::CODE_W-1:0] pool_code [POOL_KEYS];
  logic [tbft_pkg::LEN_W-1:0]  pool_len  [POOL_KEYS];

  // idling switches, changed only at phase boundaries
  bit src_idle_on  = 1'b0;
  bit sink_idle_on = 1'b0;

  int unsigned gap_left   = 0;
  int unsigned hold_left  = 0;
  int unsigned mismatches = 0;

  tail_bucket_frequency_table_core u_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_i        (in_item),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_o       (out_item),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------------
  // table model
  // ---------------------------------------------------------------------

  // zero acts as one bucket, anything above the table size as the full table
  function automatic int unsigned active_buckets(input logic [tbft_pkg::CNT_W-1:0] cnt);
    if (cnt == '0) return 1;
    if (cnt > tbft_pkg::CNT_W'(tbft_pkg::BUCKETS_DEF)) return tbft_pkg::BUCKETS_DEF;
    return int'(cnt);
  endfunction

  function automatic void claim_slot(input logic [9:0] s, input tbft_pkg::in_t item);
    tbl_code[s]  = item.key_code;
    tbl_len[s]   = item.key_length;
    tbl_freq[s]  = 16'd1;
    tbl_valid[s] = 1'b1;
  endfunction

  // applies one item to the local table; returns 0 when no result is due
  function automatic bit bucket_update(input tbft_pkg::in_t item, output tbft_pkg::out_t res);
    int unsigned                 n;
    logic [9:0]                  s;
    logic [tbft_pkg::FREQ_W-1:0] f;
    bit                          hit;
    res = '0;
    if (item.func == tbft_pkg::FUNC_CLEAR) begin
      // every bucket goes, whatever the bucket count in use
      for (int i = 0; i < tbft_pkg::BUCKETS_DEF; i++) tbl_valid[i] = 1'b0;
      res.outcome = tbft_pkg::OUT_CLEARED;
      return 1'b1;
    end
    if (item.func != tbft_pkg::FUNC_INSERT && item.func != tbft_pkg::FUNC_QUERY) return 1'b0;

    n   = active_buckets(cfg_count);
    s   = 10'(item.key_code % 64'(n));
    hit = tbl_valid[s] && tbl_code[s] == item.key_code && tbl_len[s] == item.key_length;
    res.slot_index = s;

    if (item.func == tbft_pkg::FUNC_QUERY) begin
      res.frequency = hit ? tbl_freq[s] : 16'd1;
      res.outcome   = hit ? tbft_pkg::OUT_MATCH : tbft_pkg::OUT_MISS;
      return 1'b1;
    end

    f = tbl_freq[s];
    if (!tbl_valid[s]) begin
      claim_slot(s, item);
      res.frequency = 16'd1;
      res.outcome   = tbft_pkg::OUT_NEW;
    end else if (hit) begin
      if (f != tbft_pkg::FREQ_MAX) f = f + 16'd1;
      tbl_freq[s]   = f;
      res.frequency = f;
      res.outcome   = tbft_pkg::OUT_MATCH;
    end else if (cfg_prob == tbft_pkg::MODE_DECAY) begin
      // decay: the resident key loses one count, and goes at zero
      f = f - 16'd1;
      if (f == '0) begin
        claim_slot(s, item);
        res.frequency = 16'd1;
        res.outcome   = tbft_pkg::OUT_REPLACED;
      end else begin
        tbl_freq[s]   = f;
        res.frequency = f;
        res.outcome   = tbft_pkg::OUT_KEPT;
      end
    end else begin
      // probabilistic: count up, then replace when the count divides the random word
      if (f != tbft_pkg::FREQ_MAX) f = f + 16'd1;
      tbl_freq[s] = f;
      if (f != '0 && (item.random_word % 32'(f)) == '0) begin
        claim_slot(s, item);
        res.frequency = 16'd1;
        res.outcome   = tbft_pkg::OUT_REPLACED;
      end else begin
        res.frequency = f;
        res.outcome   = tbft_pkg::OUT_KEPT;
      end
    end
    return 1'b1;
  endfunction

  // ---------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------

  // mostly short gaps, now and then a long one
  function automatic int unsigned idle_len(input bit enable);
    if (!enable) return 0;
    if ($urandom_range(0, 9) == 0) return $urandom_range(20, 150);
    return $urandom_range(0, 3);
  endfunction

  function automatic logic [tbft_pkg::CODE_W-1:0] rand_code();
    return {$urandom, $urandom};
  endfunction

  // zero always replaces, small values often do, full words seldom
  function automatic logic [tbft_pkg::RAND_W-1:0] rand_word();
    case ($urandom_range(0, 2))
      0:       return '0;
      1:       return $urandom;
      default: return tbft_pkg::RAND_W'($urandom_range(0, 7));
    endcase
  endfunction

  task automatic queue_item(input logic [1:0] func,
                            input logic [tbft_pkg::CODE_W-1:0] code,
                            input logic [tbft_pkg::LEN_W-1:0] len,
                            input logic [tbft_pkg::RAND_W-1:0] rnd);
    tbft_pkg::in_t it;
    it.func        = func;
    it.key_code    = code;
    it.key_length  = len;
    it.random_word = rnd;
    pending_items = {pending_items, it};
  endtask

  // three slots, three keys each, all landing in their slot under the count in use
  task automatic refill_pool();
    int unsigned                 n;
    logic [tbft_pkg::CODE_W-1:0] slot;
    logic [tbft_pkg::CODE_W-1:0] base;
    n = active_buckets(cfg_count);
    for (int g = 0; g < 3; g++) begin
      slot = 64'($urandom_range(0, n - 1));
      for (int k = 0; k < 3; k++) begin
        base = rand_code() >> 1;
        pool_code[3*g+k] = base - (base % 64'(n)) + slot;
        pool_len[3*g+k]  = tbft_pkg::LEN_W'($urandom_range(0, 64));
      end
    end
  endtask

  // mostly inserts of pool keys, so counts build up and collide; the rest
  // is queries, foreign keys, odd lengths, swallowed codes and clears
  function automatic tbft_pkg::in_t random_item();
    tbft_pkg::in_t it;
    int unsigned   pick;
    int unsigned   idx;
    idx            = $urandom_range(0, POOL_KEYS - 1);
    it.func        = tbft_pkg::FUNC_INSERT;
    it.key_code    = pool_code[idx];
    it.key_length  = pool_len[idx];
    it.random_word = rand_word();
    pick = $urandom_range(0, 99);
    if (pick < 10) begin
      it.key_length = tbft_pkg::LEN_W'($urandom);
    end else if (pick < 25) begin
      it.func = tbft_pkg::FUNC_QUERY;
    end else if (pick < 33) begin
      it.key_code   = rand_code();
      it.key_length = tbft_pkg::LEN_W'($urandom);
    end else if (pick < 38) begin
      it.func       = tbft_pkg::FUNC_QUERY;
      it.key_code   = rand_code();
      it.key_length = tbft_pkg::LEN_W'($urandom);
    end else if (pick < 41) begin
      it.func       = tbft_pkg::FUNC_NONE;
      it.key_code   = rand_code();
      it.key_length = tbft_pkg::LEN_W'($urandom);
    end else if (pick < 43) begin
      it.func = tbft_pkg::FUNC_CLEAR;
    end
    return it;
  endfunction

  // register write over the config channel, mirrored into the local copy
  task automatic write_cfg(input logic [tbft_pkg::CFG_IDX_W-1:0] idx,
                           input logic [tbft_pkg::CNT_W-1:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == tbft_pkg::CFG_BUCKET_COUNT) cfg_count = val;
    else cfg_prob = val[0];
  endtask

  // wait until every item is taken and every result is in, then let a
  // swallowed item finish before anything else happens
  task automatic settle();
    @(negedge clk);
    while (pending_items.size() != 0 || in_valid || awaited_results.size() != 0)
      @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic note_failure(input string what, input tbft_pkg::out_t want,
                              input tbft_pkg::out_t got);
    if (mismatches < 10)
      $display("%s: expected freq %0d outcome %0d slot %0d, got freq %0d outcome %0d slot %0d",
               what, want.frequency, want.outcome, want.slot_index,
               got.frequency, got.outcome, got.slot_index);
    mismatches++;
  endtask

  // ---------------------------------------------------------------------
  // driver: hands out pending items, predicts each one as it is taken
  // ---------------------------------------------------------------------
  always @(posedge clk or negedge rst_n) begin
    tbft_pkg::out_t res;
    if (!rst_n) begin
      in_valid <= 1'b0;
      gap_left <= 0;
    end else begin
      if (in_valid && !in_stall) begin
        if (bucket_update(in_item, res)) awaited_results = {awaited_results, res};
      end
      // payload only moves once the current item has gone
      if (!in_valid || !in_stall) begin
        if (gap_left != 0) begin
          gap_left <= gap_left - 1;
          in_valid <= 1'b0;
        end else if (pending_items.size() != 0) begin
          in_item  <= pending_items.pop_front();
          in_valid <= 1'b1;
          gap_left <= idle_len(src_idle_on);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------
  // monitor: checks results in order and throttles the output side
  // ---------------------------------------------------------------------
  always @(posedge clk or negedge rst_n) begin
    tbft_pkg::out_t want;
    int unsigned    len;
    if (!rst_n) begin
      out_stall <= 1'b0;
      hold_left <= 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (awaited_results.size() == 0) begin
          note_failure("result with nothing awaited", '0, out_item);
        end else begin
          want = awaited_results.pop_front();
          if (out_item.frequency !== want.frequency || out_item.outcome !== want.outcome ||
              out_item.slot_index !== want.slot_index)
            note_failure("result mismatch", want, out_item);
        end
      end
      // stall runs of random length between short open stretches
      if (hold_left != 0) begin
        hold_left <= hold_left - 1;
      end else if (out_stall) begin
        out_stall <= 1'b0;
        hold_left <= $urandom_range(0, 12);
      end else begin
        len = idle_len(sink_idle_on);
        if (len != 0) begin
          out_stall <= 1'b1;
          hold_left <= len - 1;
        end
      end
    end
  end

  // ---------------------------------------------------------------------
  // sequence of phases
  // ---------------------------------------------------------------------
  initial begin
    logic [tbft_pkg::CNT_W-1:0] cnt;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // reset values first, then the directed items under decay with 1024 buckets
    write_cfg(tbft_pkg::CFG_BUCKET_COUNT, tbft_pkg::BUCKET_COUNT_RST);
    write_cfg(tbft_pkg::CFG_REPLACE_MODE, tbft_pkg::CNT_W'(tbft_pkg::MODE_DECAY));
    @(negedge clk);
    sink_idle_on = 1'b1;
    queue_item(tbft_pkg::FUNC_QUERY,  64'd0, 7'd0, '0);     // miss on an empty table
    queue_item(tbft_pkg::FUNC_INSERT, 64'd0, 7'd0, '0);     // new key
    queue_item(tbft_pkg::FUNC_INSERT, 64'd0, 7'd0, '0);     // match, count two
    queue_item(tbft_pkg::FUNC_QUERY,  64'd0, 7'd0, '0);     // query hit
    queue_item(tbft_pkg::FUNC_INSERT, 64'd1024, 7'd0, '1);  // same slot, decays to one
    queue_item(tbft_pkg::FUNC_INSERT, 64'd1024, 7'd0, '1);  // decays to zero, replaced
    queue_item(tbft_pkg::FUNC_QUERY,  64'd0, 7'd0, '0);     // old key now a miss
    queue_item(tbft_pkg::FUNC_INSERT, '1, 7'd64, '1);       // all-ones key, top slot
    queue_item(tbft_pkg::FUNC_INSERT, '1, 7'd127, '0);      // same code, other length
    queue_item(tbft_pkg::FUNC_NONE,   '1, '1, '1);          // swallowed, no result
    queue_item(tbft_pkg::FUNC_QUERY,  '1, 7'd127, '0);      // hit on the newcomer
    queue_item(tbft_pkg::FUNC_QUERY,  '1, 7'd64, '0);       // evicted length misses
    queue_item(tbft_pkg::FUNC_CLEAR,  '1, '1, '1);
    queue_item(tbft_pkg::FUNC_QUERY,  '1, 7'd127, '0);      // gone after the clear
    queue_item(tbft_pkg::FUNC_INSERT, 64'h5555_5555_5555_5555, 7'd33, 32'h5555_5555);
    settle();

    // probabilistic mode with a zero bucket count, so every key shares slot 0
    write_cfg(tbft_pkg::CFG_BUCKET_COUNT, '0);
    write_cfg(tbft_pkg::CFG_REPLACE_MODE, tbft_pkg::CNT_W'(tbft_pkg::MODE_PROB));
    @(negedge clk);
    queue_item(tbft_pkg::FUNC_INSERT, 64'd5, 7'd3, '0);     // new key
    queue_item(tbft_pkg::FUNC_INSERT, 64'd9, 7'd3, '1);     // count two, odd word kept
    queue_item(tbft_pkg::FUNC_INSERT, 64'd9, 7'd3, 32'd1);  // count three, kept
    queue_item(tbft_pkg::FUNC_INSERT, 64'd9, 7'd3, '0);     // word zero, replaced
    queue_item(tbft_pkg::FUNC_INSERT, 64'd9, 7'd3, '1);     // match
    queue_item(tbft_pkg::FUNC_QUERY,  64'd5, 7'd3, '0);     // evicted key misses
    queue_item(tbft_pkg::FUNC_INSERT, 64'hAAAA_AAAA_AAAA_AAAA, 7'd64, 32'hAAAA_AAAA);
    settle();

    // random phases over a spread of bucket counts and both policies
    for (int p = 0; p < PHASES; p++) begin
      cnt = (p == 5 || p == 8) ? tbft_pkg::CNT_W'($urandom_range(1, 2047))
                               : tbft_pkg::CNT_W'(PHASE_COUNTS[p]);
      write_cfg(tbft_pkg::CFG_BUCKET_COUNT, cnt);
      write_cfg(tbft_pkg::CFG_REPLACE_MODE,
                tbft_pkg::CNT_W'((p % 2 == 0) ? tbft_pkg::MODE_PROB : tbft_pkg::MODE_DECAY));
      @(negedge clk);
      refill_pool();
      // some phases run with one or both sides flat out
      src_idle_on  = ($urandom_range(0, 3) != 0);
      sink_idle_on = ($urandom_range(0, 3) != 0);
      repeat (PHASE_ITEMS) pending_items = {pending_items, random_item()};
      settle();
    end

    // anything still awaited never came out
    mismatches += awaited_results.size();
    if (mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // hard stop, several times the slowest legal run
  initial begin
    #40_000_000;
    $display("timeout: the table stopped answering");
    $display("Some tests failed");
    $finish;
  end

endmodule

`default_nettype wire
